>>> sv/bblur_pkg.sv
`timescale 1ns / 1ps

package bblur_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    // row counter runs up to two past the last image row while draining
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);

    // configuration registers
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

    // pixel and sum widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int COLSUM_W = 10;  // up to three channel values
    localparam int SUM_W    = 12;  // up to nine channel values
    localparam int NUM_W    = 13;  // 2*sum + count
    localparam int QX_W     = 12;  // numerator after the power-of-two part of 2*count

    // odd part of the divisor 2*count
    localparam logic [1:0] DIV_BY_1 = 2'd0;
    localparam logic [1:0] DIV_BY_3 = 2'd1;
    localparam logic [1:0] DIV_BY_9 = 2'd2;

    // reciprocals rounded up, exact for numerators below 2**15
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_3 = 15'd21846;
    localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;
    localparam int PROD_W = QX_W + RECIP_W;

    // channel 0 is red in the lowest byte, then green, then blue
    typedef logic [2:0][CH_W-1:0] t_pixel;
    // three pixels of one window column, index 0 is the top row
    typedef t_pixel [2:0] t_column;
    // per-channel masked column sums
    typedef logic [2:0][COLSUM_W-1:0] t_col_sum;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic       emit;
        logic       done;
        logic [2:0] row_en;   // top, middle, bottom row inside the image
        logic [2:0] col_en;   // left, center, right column inside the image
        logic [1:0] shamt;    // power of two in 2*count
        logic [1:0] div_sel;  // odd part of 2*count
        logic [3:0] count;    // neighbors inside the image
    } t_ctrl;

endpackage

>>> sv/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps

// 3x3 box blur on an RGB pixel stream. Pixels of one frame come in raster
// order on the slave side; each result is the pixel's color averaged over
// the neighbors that lie inside the image (9 inside, 6 on edges, 4 at
// corners), rounded half up. The result for a pixel leaves with the
// transaction that comes one row plus one pixel later, so after the last
// pixel of a frame send exactly width+1 fill transactions (tuser high) to
// drain it; the last result carries tlast and the next transaction starts a
// new frame. Fills while pixels are expected are dropped, pixels during the
// drain are treated as fills. One transaction is taken per clock unless the
// output stalls; results pass the read, window, divide and output registers.
// The two line stores share one 1024-entry dual-port RAM, written back from
// the read register with a forward path, and the window is a chain of three
// column cells. Writing either register restarts the frame; write it only
// while the block is idle. Width 0 acts as 1, values above 1024 or 4096 clamp.
module box_blur_3x3_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tuser,   // is_fill
    // blurred output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast,   // frame_done
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    localparam int COL_W = bblur_pkg::COL_W;
    localparam int ROW_W = bblur_pkg::ROW_W;
    localparam int WW    = bblur_pkg::CFG_WIDTH_W;
    localparam int HW    = bblur_pkg::CFG_HEIGHT_W;
    localparam int PIX_W = bblur_pkg::PIX_W;

    // configuration and stream position
    logic [WW-1:0]    r_width;
    logic [HW-1:0]    r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             adv;
    logic             accept;
    logic             take;
    logic             draining;
    logic             col_zero;
    logic             last_col;
    logic             row_t;
    logic             row_b;
    logic             col_l;
    logic             col_r;
    logic [1:0]       n_rows;
    logic [1:0]       n_cols;
    logic [HW:0]      end_row;
    bblur_pkg::t_ctrl n_ctrl;
    bblur_pkg::t_pixel n_bot;

    // stage 1: line store read
    logic               r_s1_vld;
    logic [COL_W-1:0]   r_s1_addr;
    bblur_pkg::t_pixel  r_s1_bot;
    bblur_pkg::t_ctrl   r_s1_ctrl;
    logic               r_byp_vld;
    logic [2*PIX_W-1:0] r_byp_data;
    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] s1_rd;
    bblur_pkg::t_pixel  s1_top;
    bblur_pkg::t_pixel  s1_mid;
    bblur_pkg::t_column s1_new_col;

    // stage 2: window
    logic                r_s2_vld;
    bblur_pkg::t_ctrl    r_s2_ctrl;
    bblur_pkg::t_column  cell_r_out;
    bblur_pkg::t_column  cell_c_out;
    bblur_pkg::t_col_sum sum_l;
    bblur_pkg::t_col_sum sum_c;
    bblur_pkg::t_col_sum sum_r;

    // stage 3: divide
    logic                          r_s3_vld;
    logic                          r_s3_done;
    logic [1:0]                    r_s3_shamt;
    logic [1:0]                    r_s3_div;
    logic [bblur_pkg::NUM_W-1:0]   r_s3_num [3];
    logic [bblur_pkg::QX_W-1:0]    qx       [3];
    logic [bblur_pkg::PROD_W-1:0]  prod     [3];
    logic [bblur_pkg::RECIP_W-1:0] recip;
    bblur_pkg::t_pixel             quot;

    // output register
    logic              r_out_vld;
    logic              r_out_last;
    bblur_pkg::t_pixel r_out_pix;

    // effective frame size
    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (r_width > WW'(bblur_pkg::MAX_WIDTH)) begin
            w_eff = WW'(bblur_pkg::MAX_WIDTH);
        end
        h_eff = r_height;
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (r_height > HW'(bblur_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(bblur_pkg::MAX_HEIGHT);
        end
    end

    // handshake, the whole pipeline moves with the output register
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign draining      = r_row >= ROW_W'(h_eff);
    assign take          = accept && (!s_axis_tuser || draining);

    // position decode: window center and its neighbors inside the image
    assign col_zero = (r_col == '0);
    assign last_col = (WW'(r_col) + WW'(1)) >= w_eff;
    assign end_row  = {1'b0, h_eff} + (HW + 1)'(1);

    always_comb begin
        if (col_zero) begin
            // center is the last column of the row before
            row_t = r_row >= ROW_W'(3);
            row_b = r_row <= ROW_W'(h_eff);
            col_l = w_eff >= WW'(2);
            col_r = 1'b0;
        end else begin
            row_t = r_row >= ROW_W'(2);
            row_b = r_row < ROW_W'(h_eff);
            col_l = r_col >= COL_W'(2);
            col_r = 1'b1;
        end
        n_rows = 2'd1 + 2'(row_t) + 2'(row_b);
        n_cols = 2'd1 + 2'(col_l) + 2'(col_r);

        n_ctrl.emit   = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && !col_zero);
        n_ctrl.done   = col_zero && ({1'b0, r_row} == end_row);
        n_ctrl.row_en = {row_b, 1'b1, row_t};
        n_ctrl.col_en = {col_r, 1'b1, col_l};
        n_ctrl.shamt  = 2'd1 + 2'(n_rows == 2'd2) + 2'(n_cols == 2'd2);
        if ((n_rows == 2'd3) && (n_cols == 2'd3)) begin
            n_ctrl.div_sel = bblur_pkg::DIV_BY_9;
        end else if ((n_rows == 2'd3) || (n_cols == 2'd3)) begin
            n_ctrl.div_sel = bblur_pkg::DIV_BY_3;
        end else begin
            n_ctrl.div_sel = bblur_pkg::DIV_BY_1;
        end
        n_ctrl.count = 4'(n_rows) * 4'(n_cols);

        n_bot = draining ? '0 : bblur_pkg::t_pixel'(s_axis_tdata);
    end

    // configuration registers and stream position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bblur_pkg::RESET_WIDTH;
            r_height <= bblur_pkg::RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bblur_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                bblur_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HW-1:0];
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            if (n_ctrl.done) begin
                r_col <= '0;
                r_row <= '0;
            end else if (last_col) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // both line stores in one word: older row high, newer row low
    bblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (bblur_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata ({s1_mid, r_s1_bot}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // forward the write-back when the next read hits the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data <= {s1_mid, r_s1_bot};
            r_s1_addr  <= r_col;
            r_s1_bot   <= n_bot;
            r_s1_ctrl  <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= take;
            if (accept) begin
                r_byp_vld <= r_s1_vld && (r_s1_addr == r_col);
            end
        end
    end

    assign s1_rd      = r_byp_vld ? r_byp_data : ram_q;
    assign s1_top     = bblur_pkg::t_pixel'(s1_rd[2*PIX_W-1:PIX_W]);
    assign s1_mid     = bblur_pkg::t_pixel'(s1_rd[PIX_W-1:0]);
    assign s1_new_col = {r_s1_bot, s1_mid, s1_top};

    // window: right, center and left column cells
    bblur_cell u_cell_right (
        .i_clk    (i_clk),
        .i_shift  (adv && r_s1_vld),
        .i_col    (s1_new_col),
        .o_col    (cell_r_out),
        .i_row_en (r_s2_ctrl.row_en),
        .i_col_en (r_s2_ctrl.col_en[2]),
        .o_sum    (sum_r)
    );

    bblur_cell u_cell_center (
        .i_clk    (i_clk),
        .i_shift  (adv && r_s1_vld),
        .i_col    (cell_r_out),
        .o_col    (cell_c_out),
        .i_row_en (r_s2_ctrl.row_en),
        .i_col_en (r_s2_ctrl.col_en[1]),
        .o_sum    (sum_c)
    );

    bblur_cell u_cell_left (
        .i_clk    (i_clk),
        .i_shift  (adv && r_s1_vld),
        .i_col    (cell_c_out),
        .o_col    (),
        .i_row_en (r_s2_ctrl.row_en),
        .i_col_en (r_s2_ctrl.col_en[0]),
        .o_sum    (sum_l)
    );

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld && r_s1_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    // stage 3: window sum and rounding numerator 2*sum + count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_done  <= r_s2_ctrl.done;
            r_s3_shamt <= r_s2_ctrl.shamt;
            r_s3_div   <= r_s2_ctrl.div_sel;
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_num[ch] <= {bblur_pkg::SUM_W'(sum_l[ch])
                                 + bblur_pkg::SUM_W'(sum_c[ch])
                                 + bblur_pkg::SUM_W'(sum_r[ch]), 1'b0}
                              + bblur_pkg::NUM_W'(r_s2_ctrl.count);
            end
        end
    end

    // divide by 2*count: shift out the power of two, then scale by reciprocal
    assign recip = (r_s3_div == bblur_pkg::DIV_BY_9) ? bblur_pkg::RECIP_9
                                                     : bblur_pkg::RECIP_3;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            qx[ch]   = bblur_pkg::QX_W'(r_s3_num[ch] >> r_s3_shamt);
            prod[ch] = bblur_pkg::PROD_W'(qx[ch]) * bblur_pkg::PROD_W'(recip);
            case (r_s3_div)
                bblur_pkg::DIV_BY_3,
                bblur_pkg::DIV_BY_9: quot[ch] = prod[ch][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
                default:             quot[ch] = qx[ch][bblur_pkg::CH_W-1:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pix  <= quot;
            r_out_last <= r_s3_done;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> sv/bblur_ram.sv
`timescale 1ns / 1ps

module bblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bblur_cell.sv
`timescale 1ns / 1ps

module bblur_cell (
    input  logic                i_clk,
    input  logic                i_shift,
    input  bblur_pkg::t_column  i_col,
    output bblur_pkg::t_column  o_col,
    input  logic [2:0]          i_row_en,
    input  logic                i_col_en,
    output bblur_pkg::t_col_sum o_sum
);

    bblur_pkg::t_column r_col;

    // one window column, passed on to the older neighbor on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // masked column sum per channel
    always_comb begin
        o_sum = '0;
        if (i_col_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int row = 0; row < 3; row++) begin
                    if (i_row_en[row]) begin
                        o_sum[ch] = o_sum[ch]
                                  + bblur_pkg::COLSUM_W'(r_col[row][ch]);
                    end
                end
            end
        end
    end

endmodule
